[sv/wav_header_parser_core_assert.svh]
// Assertion macros used by the port checker of the WAV header parser.
`ifndef WAV_HEADER_PARSER_CORE_ASSERT_SVH
`define WAV_HEADER_PARSER_CORE_ASSERT_SVH

// The condition must hold at every clock edge outside reset.
`define WHP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("whp assertion failed");

// When the trigger holds, the consequence must hold in the next cycle.
`define WHP_ASSERT_NEXT(lbl, trig, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error("whp assertion failed");

`endif

[sv/whp_pkg.sv]
// Types and constants of the WAV header parser.
`default_nettype none

package whp_pkg;

  // Status codes of a result.
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BAD_RIFF = 3'd1;
  localparam logic [2:0] ST_BAD_WAVE = 3'd2;
  localparam logic [2:0] ST_NO_FMT   = 3'd3;
  localparam logic [2:0] ST_NO_DATA  = 3'd4;
  localparam logic [2:0] ST_EMPTY    = 3'd5;

  // Chunk tags as they appear in the tag shift register, first byte highest.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Default format fields held until a fmt chunk overwrites them.
  localparam logic [15:0] DEF_CHANNELS = 16'd1;
  localparam logic [31:0] DEF_RATE     = 32'd44100;
  localparam logic [15:0] DEF_BITS     = 16'd16;

  localparam int unsigned ResultWidth = 129;
  localparam int unsigned OutDataWidth = 136;

  // Members listed from the highest bit down, so status sits in the lowest bits.
  typedef struct packed {
    logic [28:0] frame_bytes;
    logic        sample_format;
    logic [31:0] data_bytes;
    logic [15:0] bits_per_sample;
    logic [31:0] rate_hz;
    logic [15:0] channel_count;
    logic [2:0]  status;
  } whp_result_t;

endpackage

`default_nettype wire

[sv/whp_parser.sv]
// Header walk state machine: one byte per enabled cycle, at most one result per file.
`default_nettype none

module whp_parser (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  step_en_i,
  input  wire [7:0]            byte_i,
  input  wire                  eof_i,
  output logic                 res_valid_o,
  output whp_pkg::whp_result_t result_o
);
  import whp_pkg::*;

  localparam logic [3:0] PH_RIFF  = 4'd0;
  localparam logic [3:0] PH_RSIZE = 4'd1;
  localparam logic [3:0] PH_WAVE  = 4'd2;
  localparam logic [3:0] PH_CTAG  = 4'd3;
  localparam logic [3:0] PH_CSIZE = 4'd4;
  localparam logic [3:0] PH_FMT   = 4'd5;
  localparam logic [3:0] PH_SKIP  = 4'd6;
  localparam logic [3:0] PH_IDLE  = 4'd7;

  logic [3:0]  phase_q, phase_d;
  logic [3:0]  k_q, k_d;
  logic [31:0] tag_q, tag_d;
  logic [31:0] size_q, size_d;
  logic [31:0] skip_q, skip_d;
  logic [15:0] ch_q, ch_d;
  logic [31:0] rate_q, rate_d;
  logic [15:0] bits_q, bits_d;
  logic        pcm_q, pcm_d;
  logic        rep_q, rep_d;

  logic [4:0]  k_inc;
  logic [31:0] skip_dec;
  logic [31:0] byte_lane;
  logic        emit;
  logic [2:0]  st;
  logic [31:0] data_b;

  always_comb begin
    phase_d   = phase_q;
    k_d       = k_q;
    tag_d     = tag_q;
    size_d    = size_q;
    skip_d    = skip_q;
    ch_d      = ch_q;
    rate_d    = rate_q;
    bits_d    = bits_q;
    pcm_d     = pcm_q;
    rep_d     = rep_q;
    emit      = 1'b0;
    st        = ST_OK;
    data_b    = '0;
    k_inc     = {1'b0, k_q} + 5'd1;
    byte_lane = {24'd0, byte_i} << {k_q[1:0], 3'b000};
    skip_dec  = (skip_q != 32'd0) ? (skip_q - 32'd1) : skip_q;

    unique case (phase_q) inside
      PH_RIFF, PH_WAVE, PH_CTAG: begin
        tag_d = {tag_q[23:0], byte_i};
        k_d   = k_inc[3:0];
        if (k_inc == 5'd4) begin
          k_d = '0;
          if (phase_q == PH_RIFF) begin
            if (tag_d != TAG_RIFF) begin
              emit    = 1'b1;
              st      = ST_BAD_RIFF;
              rep_d   = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_RSIZE;
            end
          end else if (phase_q == PH_WAVE) begin
            if (tag_d != TAG_WAVE) begin
              emit    = 1'b1;
              st      = ST_BAD_WAVE;
              rep_d   = 1'b1;
              phase_d = PH_IDLE;
            end else begin
              phase_d = PH_CTAG;
            end
          end else begin
            size_d  = '0;
            phase_d = PH_CSIZE;
          end
        end
      end
      PH_RSIZE: begin
        k_d = k_inc[3:0];
        if (k_inc == 5'd4) begin
          k_d     = '0;
          phase_d = PH_WAVE;
        end
      end
      PH_CSIZE: begin
        size_d = size_q | byte_lane;
        k_d    = k_inc[3:0];
        if (k_inc == 5'd4) begin
          k_d = '0;
          if (tag_q == TAG_FMT) begin
            phase_d = PH_FMT;
          end else if (tag_q == TAG_DATA) begin
            emit    = 1'b1;
            st      = !pcm_q ? ST_NO_FMT : ((size_d == 32'd0) ? ST_EMPTY : ST_OK);
            data_b  = size_d;
            rep_d   = 1'b1;
            phase_d = PH_IDLE;
          end else begin
            skip_d  = size_d;
            phase_d = (size_d != 32'd0) ? PH_SKIP : PH_CTAG;
          end
        end
      end
      PH_FMT: begin
        case (k_q) inside
          4'd0:    tag_d  = {24'd0, byte_i};
          4'd1:    tag_d  = tag_q | {16'd0, byte_i, 8'd0};
          4'd2:    ch_d   = {8'd0, byte_i};
          4'd3:    ch_d   = ch_q | {byte_i, 8'd0};
          4'd4:    rate_d = {24'd0, byte_i};
          4'd5, 4'd6, 4'd7: rate_d = rate_q | byte_lane;
          4'd14:   bits_d = {8'd0, byte_i};
          4'd15:   bits_d = bits_q | {byte_i, 8'd0};
          default: ;
        endcase
        k_d = k_inc[3:0];
        if (k_inc == 5'd16) begin
          k_d   = '0;
          pcm_d = (tag_d == 32'd1);
          if (size_q > 32'd16) begin
            skip_d  = size_q - 32'd16;
            phase_d = PH_SKIP;
          end else begin
            phase_d = PH_CTAG;
          end
        end
      end
      PH_SKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 32'd0) begin
          phase_d = PH_CTAG;
        end
      end
      default: ;
    endcase

    // End of stream with nothing reported yet: report where the walk stopped.
    if (eof_i && !rep_q && !emit) begin
      emit   = 1'b1;
      data_b = '0;
      if (phase_d == PH_RIFF) begin
        st = ST_BAD_RIFF;
      end else if (phase_d == PH_RSIZE || phase_d == PH_WAVE) begin
        st = ST_BAD_WAVE;
      end else begin
        st = pcm_d ? ST_NO_DATA : ST_NO_FMT;
      end
    end
  end

  always_comb begin
    res_valid_o              = emit;
    result_o.status          = st;
    result_o.channel_count   = ch_d;
    result_o.rate_hz         = rate_d;
    result_o.bits_per_sample = bits_d;
    result_o.data_bytes      = data_b;
    result_o.sample_format   = (bits_d != 16'd8);
    result_o.frame_bytes     = 29'(ch_d) * 29'(bits_d[15:3]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_RIFF;
      k_q     <= '0;
      tag_q   <= '0;
      size_q  <= '0;
      skip_q  <= '0;
      ch_q    <= DEF_CHANNELS;
      rate_q  <= DEF_RATE;
      bits_q  <= DEF_BITS;
      pcm_q   <= 1'b0;
      rep_q   <= 1'b0;
    end else if (step_en_i) begin
      if (eof_i) begin
        phase_q <= PH_RIFF;
        k_q     <= '0;
        tag_q   <= '0;
        size_q  <= '0;
        skip_q  <= '0;
        ch_q    <= DEF_CHANNELS;
        rate_q  <= DEF_RATE;
        bits_q  <= DEF_BITS;
        pcm_q   <= 1'b0;
        rep_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        k_q     <= k_d;
        tag_q   <= tag_d;
        size_q  <= size_d;
        skip_q  <= skip_d;
        ch_q    <= ch_d;
        rate_q  <= rate_d;
        bits_q  <= bits_d;
        pcm_q   <= pcm_d;
        rep_q   <= rep_d;
      end
    end
  end

endmodule

`default_nettype wire

[sv/wav_header_parser_core.sv]
// Top level of the WAV header parser: input register, parser and result register.
`default_nettype none

// The block reads a RIFF/WAVE file one byte per request on the slave stream,
// with tlast on the final byte of the file. It checks the RIFF and WAVE tags,
// walks the chunks, captures the fmt fields and sends one status request
// on the master stream per file: when the data chunk header is complete, on a
// bad tag, or at the final byte if nothing was reported before. After the
// report it drops bytes until tlast, then starts over on the next file.
// An accepted byte reaches the master side through the input register, then
// through the parser into the result register. One byte per cycle is
// sustained while the master side is ready; the parser step between the two
// registers is combinational. When the receiver stalls with a result pending,
// the held byte waits in the input register and s_axis_tready falls, so
// nothing is dropped or repeated. Reset clears the valid flags of both
// registers and returns the parser to its start state with default format
// fields of 1 channel, 44100 Hz and 16 bits.
module wav_header_parser_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [7:0]   s_axis_tdata,   // [7:0] byte_value
  input  wire          s_axis_tlast,   // end_of_file
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  // [2:0] status, [18:3] channel_count, [50:19] rate_hz,
  // [66:51] bits_per_sample, [98:67] data_bytes, [99] sample_format,
  // [128:100] frame_bytes, [135:129] zero
  output logic [135:0] m_axis_tdata
);
  import whp_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        in_eof_q;
  logic        out_valid_q, out_valid_d;
  whp_result_t out_res_q;

  logic        advance;
  logic        res_valid;
  whp_result_t res;

  // The held byte moves on when the result register is free or being drained.
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  whp_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (advance),
    .byte_i     (in_byte_q),
    .eof_i      (in_eof_q),
    .res_valid_o(res_valid),
    .result_o   (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (advance && res_valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
      in_eof_q  <= s_axis_tlast;
    end
    if (advance && res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataWidth - ResultWidth)'(0), out_res_q};

endmodule

`default_nettype wire

[sv/whp_checker.sv]
// Port-level checks of the WAV header parser, bound to the top level.
`default_nettype none

module whp_checker (
  input wire         clk_i,
  input wire         rst_ni,
  input wire         m_axis_tvalid,
  input wire         m_axis_tready,
  input wire [135:0] m_axis_tdata
);
  import whp_pkg::*;

  `include "wav_header_parser_core_assert.svh"

  logic [2:0]  status;
  logic [15:0] channels;
  logic [15:0] bits;
  logic        fmt_flag;
  logic [28:0] frame;

  assign status   = m_axis_tdata[2:0];
  assign channels = m_axis_tdata[18:3];
  assign bits     = m_axis_tdata[66:51];
  assign fmt_flag = m_axis_tdata[99];
  assign frame    = m_axis_tdata[128:100];

  `WHP_ASSERT_ALWAYS(a_status_range, !m_axis_tvalid || status <= ST_EMPTY)
  `WHP_ASSERT_ALWAYS(a_format_flag, !m_axis_tvalid || fmt_flag == (bits != 16'd8))
  `WHP_ASSERT_ALWAYS(a_frame_size, !m_axis_tvalid || frame == 29'(channels) * 29'(bits[15:3]))
  `WHP_ASSERT_NEXT(a_hold_stall, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind wav_header_parser_core whp_checker u_whp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire

[bench/testbench.sv]
// Self-checking testbench of the WAV header parser: file stimulus, parse prediction, result check.
`timescale 1ns / 1ps

module testbench;
  import whp_pkg::*;

  // Parser position inside the file as tracked by the prediction.
  typedef enum logic [3:0] {
    P_RIFF_TAG, P_RIFF_SIZE, P_WAVE_TAG, P_CHUNK_TAG,
    P_CHUNK_SIZE, P_FMT_BODY, P_SKIP_BODY, P_DONE
  } parse_pos_e;

  // Ready behavior of the result receiver.
  typedef enum logic [1:0] {RX_ALWAYS, RX_STRETCH, RX_TOGGLE} rx_mode_e;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         s_axis_tlast;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [135:0] m_axis_tdata;

  wav_header_parser_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Predicted parser state.
  parse_pos_e  pos;
  logic [3:0]  field_idx;
  logic [31:0] tag_sr;
  logic [31:0] size_sr;
  logic [31:0] skip_cnt;
  logic [15:0] held_chans;
  logic [31:0] held_rate;
  logic [15:0] held_bits;
  logic        pcm_seen;
  logic        file_reported;

  whp_result_t pending_reports[$];
  logic [7:0]  file_bytes[$];

  int       err_cnt = 0;
  int       burst_left = 0;
  bit       sender_gaps = 1'b0;
  int       rx_hold = 0;
  rx_mode_e rx_mode = RX_ALWAYS;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #(2_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction of the parser.
  // ---------------------------------------------------------------------------

  function automatic void parser_reset();
    pos           = P_RIFF_TAG;
    field_idx     = '0;
    tag_sr        = '0;
    size_sr       = '0;
    skip_cnt      = '0;
    held_chans    = DEF_CHANNELS;
    held_rate     = DEF_RATE;
    held_bits     = DEF_BITS;
    pcm_seen      = 1'b0;
    file_reported = 1'b0;
  endfunction

  function automatic void queue_report(logic [2:0] st, logic [31:0] dbytes);
    whp_result_t r;
    logic [63:0] frame;
    frame = 64'(held_chans) * 64'(held_bits / 16'd8);
    r.status          = st;
    r.channel_count   = held_chans;
    r.rate_hz         = held_rate;
    r.bits_per_sample = held_bits;
    r.data_bytes      = dbytes;
    r.sample_format   = (held_bits == 16'd8) ? 1'b0 : 1'b1;
    r.frame_bytes     = frame[28:0];
    pending_reports.push_back(r);
    file_reported = 1'b1;
  endfunction

  // Advances the predicted parser by one accepted byte.
  function automatic void parse_step(logic [7:0] b, logic is_last);
    int unsigned k;
    logic [2:0]  st;
    k = 32'(field_idx);
    case (pos)
      P_RIFF_TAG, P_WAVE_TAG, P_CHUNK_TAG: begin
        tag_sr = {tag_sr[23:0], b};
        k++;
        if (k == 4) begin
          k = 0;
          if (pos == P_RIFF_TAG) begin
            if (tag_sr != TAG_RIFF) begin
              queue_report(ST_BAD_RIFF, '0);
              pos = P_DONE;
            end else begin
              pos = P_RIFF_SIZE;
            end
          end else if (pos == P_WAVE_TAG) begin
            if (tag_sr != TAG_WAVE) begin
              queue_report(ST_BAD_WAVE, '0);
              pos = P_DONE;
            end else begin
              pos = P_CHUNK_TAG;
            end
          end else begin
            size_sr = '0;
            pos = P_CHUNK_SIZE;
          end
        end
      end
      P_RIFF_SIZE: begin
        k++;
        if (k == 4) begin
          k = 0;
          pos = P_WAVE_TAG;
        end
      end
      P_CHUNK_SIZE: begin
        size_sr = size_sr | (32'(b) << (8 * (k % 4)));
        k++;
        if (k == 4) begin
          k = 0;
          if (tag_sr == TAG_FMT) begin
            pos = P_FMT_BODY;
          end else if (tag_sr == TAG_DATA) begin
            if (!pcm_seen) st = ST_NO_FMT;
            else if (size_sr == '0) st = ST_EMPTY;
            else st = ST_OK;
            queue_report(st, size_sr);
            pos = P_DONE;
          end else begin
            skip_cnt = size_sr;
            pos = (size_sr != '0) ? P_SKIP_BODY : P_CHUNK_TAG;
          end
        end
      end
      P_FMT_BODY: begin
        // The format code lands in the tag register; the other fields update as they arrive.
        case (k)
          0: tag_sr = {24'd0, b};
          1: tag_sr[15:8] = b;
          2: held_chans = {8'd0, b};
          3: held_chans[15:8] = b;
          4: held_rate = {24'd0, b};
          5: held_rate[15:8] = b;
          6: held_rate[23:16] = b;
          7: held_rate[31:24] = b;
          14: held_bits = {8'd0, b};
          15: held_bits[15:8] = b;
          default: ;
        endcase
        k++;
        if (k == 16) begin
          k = 0;
          pcm_seen = (tag_sr == 32'd1);
          if (size_sr > 32'd16) begin
            skip_cnt = size_sr - 32'd16;
            pos = P_SKIP_BODY;
          end else begin
            pos = P_CHUNK_TAG;
          end
        end
      end
      P_SKIP_BODY: begin
        if (skip_cnt != '0) skip_cnt--;
        if (skip_cnt == '0) pos = P_CHUNK_TAG;
      end
      default: ;
    endcase
    field_idx = k[3:0];

    if (is_last) begin
      if (!file_reported) begin
        if (pos == P_RIFF_TAG) st = ST_BAD_RIFF;
        else if (pos == P_RIFF_SIZE || pos == P_WAVE_TAG) st = ST_BAD_WAVE;
        else st = pcm_seen ? ST_NO_DATA : ST_NO_FMT;
        queue_report(st, '0);
      end
      parser_reset();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result receiver and checker.
  // ---------------------------------------------------------------------------

  initial begin
    int stretch;
    bit level;
    int tick;
    stretch = 0;
    level = 1'b1;
    tick = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      tick++;
      if (rx_hold > 0) begin
        rx_hold--;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_STRETCH: begin
            if (stretch == 0) begin
              level = $urandom_range(0, 2) != 0;
              stretch = $urandom_range(1, 10);
            end
            stretch--;
            m_axis_tready <= level;
          end
          RX_TOGGLE: m_axis_tready <= (tick % 5) > 1;
          default: m_axis_tready <= 1'b1;
        endcase
      end
    end
  end

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk_i) begin
    whp_result_t got;
    whp_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[128:0];
      if (pending_reports.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected status request, expected none, actual %0h",
                 $time, m_axis_tdata);
      end else begin
        want = pending_reports.pop_front();
        compare_field("status", 32'(want.status), 32'(got.status));
        compare_field("channel_count", 32'(want.channel_count), 32'(got.channel_count));
        compare_field("rate_hz", want.rate_hz, got.rate_hz);
        compare_field("bits_per_sample", 32'(want.bits_per_sample),
                      32'(got.bits_per_sample));
        compare_field("data_bytes", want.data_bytes, got.data_bytes);
        compare_field("sample_format", 32'(want.sample_format), 32'(got.sample_format));
        compare_field("frame_bytes", 32'(want.frame_bytes), 32'(got.frame_bytes));
        compare_field("padding", 32'd0, 32'(m_axis_tdata[135:129]));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Byte sender and file builders.
  // ---------------------------------------------------------------------------

  // Called at a falling edge; returns at the falling edge after the byte was taken.
  task automatic send_byte(logic [7:0] b, logic is_last);
    if (sender_gaps && burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= is_last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    parse_step(b, is_last);
    @(negedge clk_i);
  endtask

  task automatic send_file();
    foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
    file_bytes.delete();
  endtask

  // Lowers the request and waits until every predicted status has been received.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (pending_reports.size() != 0) @(negedge clk_i);
  endtask

  function automatic void add_tag(logic [31:0] tag);
    for (int i = 3; i >= 0; i--) file_bytes.push_back(tag[8*i +: 8]);
  endfunction

  function automatic void add_le(logic [31:0] v, int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void add_raw(int n);
    for (int i = 0; i < n; i++) file_bytes.push_back(8'($urandom));
  endfunction

  function automatic void add_head();
    add_tag(TAG_RIFF);
    add_le($urandom, 4);
    add_tag(TAG_WAVE);
  endfunction

  // A fmt chunk always carries 16 body bytes, plus any excess its size announces.
  function automatic void add_fmt(logic [15:0] code, logic [15:0] chans, logic [31:0] rate,
                                  logic [15:0] bits, logic [31:0] size);
    add_tag(TAG_FMT);
    add_le(size, 4);
    add_le(32'(code), 2);
    add_le(32'(chans), 2);
    add_le(rate, 4);
    add_le($urandom, 4);
    add_le($urandom, 2);
    add_le(32'(bits), 2);
    if (size > 32'd16) add_raw(int'(size - 32'd16));
  endfunction

  function automatic void add_data(logic [31:0] size);
    add_tag(TAG_DATA);
    add_le(size, 4);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Tag errors and streams that end inside the RIFF header.
  task automatic test_tag_errors();
    file_bytes.push_back(8'hFF);
    send_file();
    file_bytes = '{8'h52, 8'h49};
    send_file();
    file_bytes = '{8'h52, 8'h49, 8'h46, 8'h58, 8'h00};
    send_file();
    add_tag(TAG_RIFF);
    add_le(32'hFFFF_0000, 4);
    add_tag(32'h5741_5658);
    send_file();
    add_tag(TAG_RIFF);
    add_le(32'h0000_00FF, 2);
    send_file();
    wait_drained();
  endtask

  // Hand-built files covering each chunk-walk outcome.
  task automatic test_chunk_cases();
    // Stereo 8-bit PCM with four sample bytes after the header.
    add_head(); add_fmt(16'd1, 16'd2, 32'd22050, 16'd8, 32'd16); add_data(32'd4); add_raw(4);
    send_file();
    // Data chunk of zero length.
    add_head(); add_fmt(16'd1, 16'd1, 32'd8000, 16'd16, 32'd16); add_data(32'd0); add_raw(1);
    send_file();
    // Data chunk before any fmt chunk.
    add_head(); add_data(32'd8); add_raw(2);
    send_file();
    // Floating-point format code is not PCM.
    add_head(); add_fmt(16'd3, 16'd2, 32'd48000, 16'd32, 32'd16); add_data(32'd16);
    send_file();
    // Short fmt size, an odd-sized chunk without pad byte, then an empty chunk.
    add_head(); add_fmt(16'd1, 16'd6, 32'd96000, 16'd24, 32'd2);
    add_tag(32'h4C49_5354); add_le(32'd3, 4); add_raw(3);
    add_tag(32'h4A55_4E4B); add_le(32'd0, 4);
    add_data(32'd5);
    send_file();
    // All fields at their maximum, with two excess fmt bytes.
    add_head(); add_fmt(16'd1, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd18);
    add_data(32'hFFFF_FFFF); add_raw(1);
    send_file();
    // The second fmt chunk replaces the first.
    add_head(); add_fmt(16'd1, 16'd2, 32'd44100, 16'd16, 32'd16);
    add_fmt(16'd1, 16'd1, 32'd11025, 16'd8, 32'd16); add_data(32'd1);
    send_file();
    // Stream ends inside the data chunk header.
    add_head(); add_fmt(16'd1, 16'd2, 32'd32000, 16'd16, 32'd16);
    add_tag(TAG_DATA); add_le(32'd7, 2);
    send_file();
    // Stream ends inside the fmt body, before the format is settled.
    add_head(); add_tag(TAG_FMT); add_le(32'd16, 4); add_raw(6);
    send_file();
    // Stream ends while skipping an unknown chunk after a valid fmt.
    add_head(); add_fmt(16'd1, 16'd1, 32'd16000, 16'd8, 32'd16);
    add_tag(32'h4C49_5354); add_le(32'd100, 4); add_raw(5);
    send_file();
    // The final byte is also the last byte of the data chunk header.
    add_head(); add_fmt(16'd1, 16'd2, 32'd44100, 16'd16, 32'd16); add_data(32'd64);
    send_file();
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while short files keep arriving back to back.
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    rx_hold = 300;
    for (int f = 0; f < 12; f++) begin
      file_bytes = '{8'h52, 8'h49, 8'h46, 8'(f), 8'(~f)};
      send_file();
    end
    wait_drained();
  endtask

  // Builds one random file: mostly well-formed with random content, some noise,
  // some with a corrupted byte and some cut short.
  function automatic void build_random_file();
    int kind;
    int cut;
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] size;
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      add_raw($urandom_range(1, 12));
      return;
    end
    add_head();
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: chans = 16'd1;
          1: chans = 16'd2;
          2: chans = 16'hFFFF;
          default: chans = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0: bits = 16'd8;
          1: bits = 16'd16;
          2: bits = 16'd24;
          default: bits = 16'($urandom);
        endcase
        case ($urandom_range(0, 3))
          0: size = $urandom_range(0, 15);
          1: size = $urandom_range(17, 22);
          default: size = 32'd16;
        endcase
        add_fmt(($urandom_range(0, 4) != 0) ? 16'd1 : 16'($urandom), chans, $urandom,
                bits, size);
      end else begin
        size = ($urandom_range(0, 15) == 0) ? $urandom : $urandom_range(0, 6);
        add_tag($urandom);
        add_le(size, 4);
        add_raw((size > 32'd6) ? 4 : int'(size));
      end
    end
    if ($urandom_range(0, 9) != 0) begin
      case ($urandom_range(0, 3))
        0: size = 32'd0;
        1: size = $urandom_range(1, 8);
        2: size = 32'hFFFF_FFFF;
        default: size = $urandom;
      endcase
      add_data(size);
      add_raw($urandom_range(0, 4));
    end
    if (kind == 1) begin
      file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
    end else if (kind == 2) begin
      cut = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > cut) void'(file_bytes.pop_back());
    end
  endfunction

  // Random files until this test has sent at least 420 bytes.
  task automatic test_random_files();
    int bytes_sent;
    int files_sent;
    bytes_sent = 0;
    files_sent = 0;
    while (bytes_sent < 420) begin
      if (files_sent % 4 == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 2));
        sender_gaps = 1'($urandom_range(0, 1));
      end
      build_random_file();
      bytes_sent += file_bytes.size();
      send_file();
      files_sent++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of tests.
  // ---------------------------------------------------------------------------

  initial begin
    int guard;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    parser_reset();
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    rx_mode = RX_ALWAYS;
    test_tag_errors();
    rx_mode = RX_STRETCH;
    sender_gaps = 1'b1;
    test_chunk_cases();
    test_backpressure();
    test_random_files();

    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_reports.size() != 0 && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (8) @(negedge clk_i);
    if (pending_reports.size() != 0) begin
      err_cnt++;
      $display("%0t: %0d status requests never arrived, expected 0, actual %0d", $time,
               pending_reports.size(), pending_reports.size());
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

[wav_header_parser_core.f]
+incdir+sv
sv/whp_pkg.sv
sv/whp_parser.sv
sv/wav_header_parser_core.sv
sv/whp_checker.sv
bench/testbench.sv
